[rtl/rvep_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Euler pole pipeline.
// Depends on nothing; the other files of the block, but for the two interfaces, refer to it by scoped names.
package rvep_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  // Width of the CORDIC data path (signed) and of the angle path (signed Q24 degrees).
  localparam int CW = 52;
  localparam int AW = 34;
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_TIME_SCALE     = 2'd0,
    REG_VELOCITY_RATIO = 2'd1,
    REG_EARTH_RADIUS   = 2'd2
  } reg_idx_t;

  localparam logic [31:0] TIME_SCALE_RST     = 32'd65536;
  localparam logic [31:0] VELOCITY_RATIO_RST = 32'd65536;
  localparam logic [15:0] EARTH_RADIUS_RST   = 16'd6371;

  localparam logic [46:0] COMP_SAT = 47'h7FFF_FFFF_FFFF;
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
  localparam logic [25:0] RATE_CONST = 26'd57295780;
  localparam logic signed [AW-1:0] DEG180_Q24 = 34'sd3019898880;
  localparam logic signed [AW-1:0] LAT_MAX = 34'sd5898240;
  localparam logic signed [AW-1:0] LON_MAX = 34'sd11796480;
  localparam logic signed [AW:0] RND_Q8 = 35'sd128;

  typedef struct packed {
    logic [31:0] time_scale;
    logic [31:0] velocity_ratio;
    logic [15:0] earth_radius;
  } cfg_t;

  // Carried alongside the longitude pass.
  typedef struct packed {
    logic [7:0]         plate;
    logic               zero;
    logic [5:0]         shift;
    logic               hzero;
    logic signed [47:0] z;
  } side1_t;

  // Carried alongside the latitude pass.
  typedef struct packed {
    logic [7:0]         plate;
    logic               zero;
    logic [5:0]         shift;
    logic signed [24:0] lon;
  } side2_t;

  // Carried through the rate stages.
  typedef struct packed {
    logic [7:0]         plate;
    logic               zero;
    logic signed [23:0] lat;
    logic signed [24:0] lon;
  } bside_t;

  // atan(2^-i) in degrees, Q24.
  function automatic logic [29:0] atan_q24(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0: r = 30'd754974720;
      5'd1: r = 30'd445687602;
      5'd2: r = 30'd235489088;
      5'd3: r = 30'd119537938;
      5'd4: r = 30'd60000934;
      5'd5: r = 30'd30029717;
      5'd6: r = 30'd15018523;
      5'd7: r = 30'd7509720;
      5'd8: r = 30'd3754917;
      5'd9: r = 30'd1877466;
      5'd10: r = 30'd938734;
      5'd11: r = 30'd469367;
      5'd12: r = 30'd234684;
      5'd13: r = 30'd117342;
      5'd14: r = 30'd58671;
      5'd15: r = 30'd29335;
      5'd16: r = 30'd14668;
      5'd17: r = 30'd7334;
      5'd18: r = 30'd3667;
      5'd19: r = 30'd1833;
      5'd20: r = 30'd917;
      5'd21: r = 30'd458;
      5'd22: r = 30'd229;
      5'd23: r = 30'd115;
      5'd24: r = 30'd57;
      5'd25: r = 30'd29;
      5'd26: r = 30'd14;
      5'd27: r = 30'd7;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Round a Q24 angle to Q16 and clamp it to plus or minus lim.
  function automatic logic signed [AW-1:0] q24_to_q16(input logic signed [AW-1:0] a,
                                                      input logic signed [AW-1:0] lim);
    logic signed [AW:0] t;
    logic signed [AW:0] hi;
    logic signed [AW:0] lo;
    hi = (AW+1)'(lim);
    lo = -hi;
    t = (AW+1)'(a) + RND_Q8;
    t = t >>> 8;
    if (t > hi) begin
      t = hi;
    end else if (t < lo) begin
      t = lo;
    end
    return AW'(t);
  endfunction

endpackage

[rtl/rvep_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one rotation vector and its plate number per transfer.
// Depends on nothing.
interface rvep_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         plate_number;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;

  modport source (output valid, output plate_number, output rot_x, output rot_y,
                  output rot_z, input ready);
  modport sink (input valid, input plate_number, input rot_x, input rot_y,
                input rot_z, output ready);
endinterface

[rtl/rvep_out_if.sv]
`timescale 1ns / 1ps
// Output channel: one Euler pole result per transfer.
// Depends on nothing.
interface rvep_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         plate_id_out;
  logic [31:0]        rotation_rate;
  logic signed [23:0] pole_latitude;
  logic signed [24:0] pole_longitude;
  logic               zero_vector;

  modport source (output valid, output plate_id_out, output rotation_rate,
                  output pole_latitude, output pole_longitude, output zero_vector,
                  input ready);
  modport sink (input valid, input plate_id_out, input rotation_rate,
                input pole_latitude, input pole_longitude, input zero_vector,
                output ready);
endinterface

[rtl/rvep_regs.sv]
`timescale 1ns / 1ps
// APB-style configuration registers of the Euler pole block.
// Depends on rvep_pkg.
module rvep_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rvep_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rvep_pkg::cfg_t              cfg
);

  logic wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_scale     <= rvep_pkg::TIME_SCALE_RST;
      cfg.velocity_ratio <= rvep_pkg::VELOCITY_RATIO_RST;
      cfg.earth_radius   <= rvep_pkg::EARTH_RADIUS_RST;
    end else if (wr) begin
      case (idx)
        rvep_pkg::REG_TIME_SCALE:     cfg.time_scale <= pwdata;
        rvep_pkg::REG_VELOCITY_RATIO: cfg.velocity_ratio <= pwdata;
        rvep_pkg::REG_EARTH_RADIUS:   cfg.earth_radius <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rvep_pkg::REG_TIME_SCALE:     prdata = cfg.time_scale;
      rvep_pkg::REG_VELOCITY_RATIO: prdata = cfg.velocity_ratio;
      rvep_pkg::REG_EARTH_RADIUS:   prdata = {16'd0, cfg.earth_radius};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

[rtl/rvep_front.sv]
`timescale 1ns / 1ps
// Front end: gain scaling, saturation, common normalization and the
// half-plane fold ahead of the longitude pass. Depends on rvep_pkg.
module rvep_front (
  input  logic                           clk,
  input  logic                           rst,
  input  rvep_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     plate_number,
  input  logic signed [31:0]             rot_x,
  input  logic signed [31:0]             rot_y,
  input  logic signed [31:0]             rot_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [rvep_pkg::CW-1:0] out_x,
  output logic signed [rvep_pkg::CW-1:0] out_y,
  output logic signed [rvep_pkg::AW-1:0] out_a,
  output rvep_pkg::side1_t               out_side
);

  localparam int NS = 6;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic [7:0]  plate_r [NS];
  logic [2:0]  neg_r [NS];

  logic signed [31:0] rot [3];
  logic [31:0] mag [3];
  logic [63:0] p0 [3];
  logic [46:0] m1 [3];
  logic [63:0] lo1 [3];
  logic [46:0] hi1 [3];
  logic [63:0] m2c [3];
  logic [46:0] m2 [3];
  logic [46:0] mag3 [3];
  logic [46:0] mx3;
  logic        zero3;
  logic [46:0] mag4 [3];
  logic [46:0] mx4;
  logic [5:0]  s4;
  logic        zero4;
  logic [46:0] mag5 [3];
  logic [5:0]  s5;
  logic        zero5;

  logic [46:0] mx_c;
  logic [46:0] sh4_m [3];
  logic [46:0] sh4_x;
  logic [5:0]  sh4_s;
  logic [46:0] sh5_m [3];
  logic [46:0] sh5_x;
  logic [5:0]  sh5_s;

  logic signed [47:0] c [3];
  logic               hz;
  logic               xneg;
  logic               ynonneg;

  assign rdy[NS] = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = v[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      plate_r[0] <= plate_number;
      neg_r[0]   <= {rot_z[31], rot_y[31], rot_x[31]};
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        plate_r[k] <= plate_r[k-1];
        neg_r[k]   <= neg_r[k-1];
      end
    end
  end

  assign rot[0] = rot_x;
  assign rot[1] = rot_y;
  assign rot[2] = rot_z;

  for (genvar k = 0; k < 3; k++) begin : g_scale
    // Magnitude of a two's complement word; the most negative value maps to 2^31.
    assign mag[k] = rot[k][31] ? (~rot[k] + 32'd1) : rot[k];
    assign p0[k]  = mag[k] * cfg.time_scale;
    assign m2c[k] = {1'b0, hi1[k], 16'd0} + {16'd0, lo1[k][63:16]};
    assign m2[k]  = (m2c[k] > {17'd0, rvep_pkg::COMP_SAT}) ? rvep_pkg::COMP_SAT : m2c[k][46:0];

    always_ff @(posedge clk) begin
      if (rdy[0]) m1[k] <= p0[k][62:16];
      if (rdy[1]) begin
        lo1[k] <= m1[k][31:0] * cfg.velocity_ratio;
        hi1[k] <= m1[k][46:32] * cfg.velocity_ratio;
      end
      if (rdy[2]) mag3[k] <= m2[k];
    end
  end

  always_comb begin
    mx_c = m2[0];
    if (m2[1] > mx_c) mx_c = m2[1];
    if (m2[2] > mx_c) mx_c = m2[2];
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      mx3   <= mx_c;
      zero3 <= (mx_c == 47'd0);
    end
  end

  // Leading-one search in two stages: shifts of 32, 16, 8, then 4, 2, 1.
  always_comb begin
    sh4_x = mx3;
    sh4_s = 6'd0;
    for (int k = 0; k < 3; k++) sh4_m[k] = mag3[k];
    if (sh4_x[46:15] == 32'd0) begin
      sh4_x = sh4_x << 32;
      sh4_s[5] = 1'b1;
      for (int k = 0; k < 3; k++) sh4_m[k] = sh4_m[k] << 32;
    end
    if (sh4_x[46:31] == 16'd0) begin
      sh4_x = sh4_x << 16;
      sh4_s[4] = 1'b1;
      for (int k = 0; k < 3; k++) sh4_m[k] = sh4_m[k] << 16;
    end
    if (sh4_x[46:39] == 8'd0) begin
      sh4_x = sh4_x << 8;
      sh4_s[3] = 1'b1;
      for (int k = 0; k < 3; k++) sh4_m[k] = sh4_m[k] << 8;
    end
  end

  always_comb begin
    sh5_x = mx4;
    sh5_s = s4;
    for (int k = 0; k < 3; k++) sh5_m[k] = mag4[k];
    if (sh5_x[46:43] == 4'd0) begin
      sh5_x = sh5_x << 4;
      sh5_s[2] = 1'b1;
      for (int k = 0; k < 3; k++) sh5_m[k] = sh5_m[k] << 4;
    end
    if (sh5_x[46:45] == 2'd0) begin
      sh5_x = sh5_x << 2;
      sh5_s[1] = 1'b1;
      for (int k = 0; k < 3; k++) sh5_m[k] = sh5_m[k] << 2;
    end
    if (sh5_x[46] == 1'b0) begin
      sh5_s[0] = 1'b1;
      for (int k = 0; k < 3; k++) sh5_m[k] = sh5_m[k] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      mx4   <= sh4_x;
      s4    <= sh4_s;
      zero4 <= zero3;
      for (int k = 0; k < 3; k++) mag4[k] <= sh4_m[k];
    end
    if (rdy[4]) begin
      s5    <= sh5_s;
      zero5 <= zero4;
      for (int k = 0; k < 3; k++) mag5[k] <= sh5_m[k];
    end
  end

  // Signed components and the fold of the left half plane.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c[k] = neg_r[4][k] ? -$signed({1'b0, mag5[k]}) : $signed({1'b0, mag5[k]});
    end
    hz      = (mag5[0] == 47'd0) && (mag5[1] == 47'd0);
    xneg    = neg_r[4][0] && (mag5[0] != 47'd0);
    ynonneg = !(neg_r[4][1] && (mag5[1] != 47'd0));
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      if (xneg) begin
        out_x <= -rvep_pkg::CW'(c[0]);
        out_y <= -rvep_pkg::CW'(c[1]);
        out_a <= ynonneg ? rvep_pkg::DEG180_Q24 : -rvep_pkg::DEG180_Q24;
      end else begin
        out_x <= rvep_pkg::CW'(c[0]);
        out_y <= rvep_pkg::CW'(c[1]);
        out_a <= '0;
      end
      out_side.plate <= plate_r[4];
      out_side.zero  <= zero5;
      out_side.shift <= s5;
      out_side.hzero <= hz;
      out_side.z     <= c[2];
    end
  end

endmodule

[rtl/rvep_cordic.sv]
`timescale 1ns / 1ps
// Unrolled CORDIC vectoring pass, one micro-rotation per register stage,
// with a sideband word that travels with each item. Depends on rvep_pkg.
module rvep_cordic #(
  parameter int STEPS = rvep_pkg::CORDIC_STEPS_DEF,
  parameter int SW = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [rvep_pkg::CW-1:0] in_x,
  input  logic signed [rvep_pkg::CW-1:0] in_y,
  input  logic signed [rvep_pkg::AW-1:0] in_a,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [rvep_pkg::CW-1:0] out_x,
  output logic signed [rvep_pkg::CW-1:0] out_y,
  output logic signed [rvep_pkg::AW-1:0] out_a,
  output logic [SW-1:0]                  out_side
);

  logic [STEPS-1:0] v;
  logic [STEPS:0]   rdy;
  logic signed [rvep_pkg::CW-1:0] xs [STEPS];
  logic signed [rvep_pkg::CW-1:0] ys [STEPS];
  logic signed [rvep_pkg::AW-1:0] as [STEPS];
  logic [SW-1:0] sd [STEPS];

  assign rdy[STEPS] = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = v[STEPS-1];
  assign out_x = xs[STEPS-1];
  assign out_y = ys[STEPS-1];
  assign out_a = as[STEPS-1];
  assign out_side = sd[STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic                           pv;
    logic signed [rvep_pkg::CW-1:0] px;
    logic signed [rvep_pkg::CW-1:0] py;
    logic signed [rvep_pkg::AW-1:0] pa;
    logic [SW-1:0]                  ps;
    logic signed [rvep_pkg::CW-1:0] dx;
    logic signed [rvep_pkg::CW-1:0] dy;
    logic signed [rvep_pkg::AW-1:0] da;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign px = in_x;
      assign py = in_y;
      assign pa = in_a;
      assign ps = in_side;
    end else begin : g_next
      assign pv = v[i-1];
      assign px = xs[i-1];
      assign py = ys[i-1];
      assign pa = as[i-1];
      assign ps = sd[i-1];
    end

    assign rdy[i] = !v[i] || rdy[i+1];
    assign dx = py >>> i;
    assign dy = px >>> i;
    assign da = $signed({{(rvep_pkg::AW-30){1'b0}}, rvep_pkg::atan_q24(5'(i))});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        if (py >= 0) begin
          xs[i] <= px + dx;
          ys[i] <= py - dy;
          as[i] <= pa + da;
        end else begin
          xs[i] <= px - dx;
          ys[i] <= py + dy;
          as[i] <= pa - da;
        end
        sd[i] <= ps;
      end
    end
  end

endmodule

[rtl/rvep_mid.sv]
`timescale 1ns / 1ps
// Between the two passes: gain removal on the horizontal length and
// rounding of the longitude. Depends on rvep_pkg.
module rvep_mid (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [rvep_pkg::CW-1:0] in_x,
  input  logic signed [rvep_pkg::AW-1:0] in_a,
  input  rvep_pkg::side1_t               in_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [rvep_pkg::CW-1:0] out_x,
  output logic signed [rvep_pkg::CW-1:0] out_y,
  output logic signed [rvep_pkg::AW-1:0] out_a,
  output rvep_pkg::side2_t               out_side
);

  localparam int XW = rvep_pkg::CW - 1;

  logic [1:0] v;
  logic [2:0] rdy;

  logic [XW-1:0]     xp;
  logic [XW-1:0]     ph;
  logic [63:0]       pl;
  logic signed [24:0] lon0;
  rvep_pkg::side1_t  sd0;
  logic [rvep_pkg::CW-1:0] r;

  assign rdy[2] = out_ready;
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign in_ready = rdy[0];
  assign out_valid = v[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
    end
  end

  assign xp = in_x[rvep_pkg::CW-1] ? '0 : in_x[XW-1:0];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ph   <= XW'(xp[XW-1:32] * rvep_pkg::INV_GAIN_Q32);
      pl   <= xp[31:0] * rvep_pkg::INV_GAIN_Q32;
      lon0 <= 25'(rvep_pkg::q24_to_q16(in_a, rvep_pkg::LON_MAX));
      sd0  <= in_side;
    end
  end

  assign r = {1'b0, ph} + {20'd0, pl[63:32]};

  // No horizontal part: length and longitude are both zero.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      out_x <= sd0.hzero ? '0 : $signed({1'b0, r[XW-1:0]});
      out_y <= rvep_pkg::CW'(sd0.z);
      out_a <= '0;
      out_side.plate <= sd0.plate;
      out_side.zero  <= sd0.zero;
      out_side.shift <= sd0.shift;
      out_side.lon   <= sd0.hzero ? '0 : lon0;
    end
  end

endmodule

[rtl/rvep_back.sv]
`timescale 1ns / 1ps
// Back end: gain removal on the magnitude, denormalization, the rate
// product and a pipelined restoring divider. Depends on rvep_pkg.
module rvep_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [15:0]                    earth_radius,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [rvep_pkg::CW-1:0] in_x,
  input  logic signed [rvep_pkg::AW-1:0] in_a,
  input  rvep_pkg::side2_t               in_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     plate_id_out,
  output logic [31:0]                    rotation_rate,
  output logic signed [23:0]             pole_latitude,
  output logic signed [24:0]             pole_longitude,
  output logic                           zero_vector
);

  localparam int XW = rvep_pkg::CW - 1;
  localparam int DS = 8;          // divider stages, four quotient bits each
  localparam int NS = 6 + DS;     // B0..B4, divider, output register

  logic [NS-1:0] v;
  logic [NS:0]   rdy;
  rvep_pkg::bside_t bs [NS-1];

  logic [15:0] erad;
  logic [XW-1:0] xp;
  logic [XW-1:0] ph;
  logic [63:0]   pl;
  logic [5:0]    s0;
  logic [5:0]    s1;
  logic [rvep_pkg::CW-1:0] m1;
  logic [rvep_pkg::CW:0]   rnd;
  logic [rvep_pkg::CW:0]   m2;
  logic          sat3;
  logic [57:0]   ml3;
  logic [30:0]   mh3;
  logic [63:0]   num;

  logic [15:0] drem [DS+1];
  logic [31:0] dlo [DS+1];
  logic [31:0] dq [DS+1];
  logic        dsat [DS+1];

  assign erad = (earth_radius == 16'd0) ? 16'd1 : earth_radius;

  assign rdy[NS] = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = v[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // Sideband of each item, with the latitude rounded on entry.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      bs[0].plate <= in_side.plate;
      bs[0].zero  <= in_side.zero;
      bs[0].lon   <= in_side.lon;
      bs[0].lat   <= 24'(rvep_pkg::q24_to_q16(in_a, rvep_pkg::LAT_MAX));
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) bs[k] <= bs[k-1];
    end
  end

  // B0: gain removal products.
  assign xp = in_x[rvep_pkg::CW-1] ? '0 : in_x[XW-1:0];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ph <= XW'(xp[XW-1:32] * rvep_pkg::INV_GAIN_Q32);
      pl <= xp[31:0] * rvep_pkg::INV_GAIN_Q32;
      s0 <= in_side.shift;
    end
  end

  // B1: magnitude with the gain removed.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      m1 <= {1'b0, ph} + {20'd0, pl[63:32]};
      s1 <= s0;
    end
  end

  // B2: undo the normalization, rounding to nearest.
  assign rnd = ((rvep_pkg::CW+1)'(1) << s1) >> 1;

  always_ff @(posedge clk) begin
    if (rdy[2]) m2 <= ({1'b0, m1} + rnd) >> s1;
  end

  // B3: rate product, split at bit 32.
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sat3 <= (m2[rvep_pkg::CW:37] != '0);
      ml3  <= m2[31:0] * rvep_pkg::RATE_CONST;
      mh3  <= m2[36:32] * rvep_pkg::RATE_CONST;
    end
  end

  // B4: numerator with rounding term; a quotient of 2^32 or more saturates.
  assign num = {1'b0, mh3, 32'd0} + {6'd0, ml3} + {49'd0, erad[15:1]};

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      dsat[0] <= sat3 || (num[63:32] >= {16'd0, erad});
      drem[0] <= num[47:32];
      dlo[0]  <= num[31:0];
      dq[0]   <= 32'd0;
    end
  end

  for (genvar d = 0; d < DS; d++) begin : g_div
    logic [15:0] rem_c;
    logic [31:0] lo_c;
    logic [31:0] q_c;
    logic [16:0] t;

    always_comb begin
      rem_c = drem[d];
      lo_c  = dlo[d];
      q_c   = dq[d];
      t     = '0;
      for (int j = 0; j < 4; j++) begin
        t    = {rem_c, lo_c[31]};
        lo_c = lo_c << 1;
        if (t >= {1'b0, erad}) begin
          rem_c = 16'(t - {1'b0, erad});
          q_c   = {q_c[30:0], 1'b1};
        end else begin
          rem_c = t[15:0];
          q_c   = {q_c[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[5+d]) begin
        drem[d+1] <= rem_c;
        dlo[d+1]  <= lo_c;
        dq[d+1]   <= q_c;
        dsat[d+1] <= dsat[d];
      end
    end
  end

  // Output register; a zero vector forces the rate, latitude and longitude to zero.
  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      plate_id_out <= bs[NS-2].plate;
      zero_vector  <= bs[NS-2].zero;
      if (bs[NS-2].zero) begin
        rotation_rate  <= 32'd0;
        pole_latitude  <= '0;
        pole_longitude <= '0;
      end else begin
        rotation_rate  <= dsat[DS] ? 32'hFFFF_FFFF : dq[DS];
        pole_latitude  <= bs[NS-2].lat;
        pole_longitude <= bs[NS-2].lon;
      end
    end
  end

endmodule

[rtl/rotation_vector_to_euler_pole.sv]
`timescale 1ns / 1ps
// Top level of the Euler pole block: registers, front end, two CORDIC passes
// and the rate back end. Depends on rvep_pkg, rvep_in_if, rvep_out_if and all rvep_ modules.
//
//  channel  direction  transfer moves
//  -------  ---------  ---------------------------------------------------
//  vec      sink       plate_number, rot_x, rot_y, rot_z (valid/ready)
//  pole     source     plate_id_out, rotation_rate, pole_latitude,
//                      pole_longitude, zero_vector (valid/ready)
//  APB      slave      time_scale, velocity_ratio, earth_radius registers
//
// One vector enters per clock cycle while no stall backs up to vec. The depth is set
// by the two unrolled CORDIC passes and the 8-stage divider that forms the rate.
// Reset (rst, synchronous) empties every stage and loads the register defaults.
// Every stage holds its item while the stage after it is full and stalled, so a
// stall at the output backs up only as far as the pipeline is full; empty stages
// keep filling, and vec stays ready until the pipeline has no bubble left.
module rotation_vector_to_euler_pole #(
  parameter int CORDIC_STEPS = rvep_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rvep_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  rvep_in_if.sink                     vec,
  rvep_out_if.source                  pole
);

  rvep_pkg::cfg_t cfg;

  // Front end to the longitude pass.
  logic                           f_valid;
  logic                           f_ready;
  logic signed [rvep_pkg::CW-1:0] f_x;
  logic signed [rvep_pkg::CW-1:0] f_y;
  logic signed [rvep_pkg::AW-1:0] f_a;
  rvep_pkg::side1_t               f_side;

  // Longitude pass to the mid stage.
  logic                           c1_valid;
  logic                           c1_ready;
  logic signed [rvep_pkg::CW-1:0] c1_x;
  logic signed [rvep_pkg::CW-1:0] c1_y;
  logic signed [rvep_pkg::AW-1:0] c1_a;
  rvep_pkg::side1_t               c1_side;

  // Mid stage to the latitude pass.
  logic                           m_valid;
  logic                           m_ready;
  logic signed [rvep_pkg::CW-1:0] m_x;
  logic signed [rvep_pkg::CW-1:0] m_y;
  logic signed [rvep_pkg::AW-1:0] m_a;
  rvep_pkg::side2_t               m_side;

  // Latitude pass to the back end. The residual y of this pass is not needed.
  logic                           c2_valid;
  logic                           c2_ready;
  logic signed [rvep_pkg::CW-1:0] c2_x;
  logic signed [rvep_pkg::CW-1:0] c2_y;
  logic signed [rvep_pkg::AW-1:0] c2_a;
  rvep_pkg::side2_t               c2_side;

  rvep_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Scaling by both gains, component saturation, common normalization and the half-plane fold.
  rvep_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (vec.valid),
    .in_ready     (vec.ready),
    .plate_number (vec.plate_number),
    .rot_x        (vec.rot_x),
    .rot_y        (vec.rot_y),
    .rot_z        (vec.rot_z),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_x        (f_x),
    .out_y        (f_y),
    .out_a        (f_a),
    .out_side     (f_side)
  );

  // First pass on (x, y): longitude and the horizontal length.
  rvep_cordic #(
    .STEPS (CORDIC_STEPS),
    .SW    ($bits(rvep_pkg::side1_t))
  ) u_cordic_lon (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_x      (f_x),
    .in_y      (f_y),
    .in_a      (f_a),
    .in_side   (f_side),
    .out_valid (c1_valid),
    .out_ready (c1_ready),
    .out_x     (c1_x),
    .out_y     (c1_y),
    .out_a     (c1_a),
    .out_side  (c1_side)
  );

  rvep_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c1_valid && (c1_y == c1_y)),
    .in_ready  (c1_ready),
    .in_x      (c1_x),
    .in_a      (c1_a),
    .in_side   (c1_side),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_x     (m_x),
    .out_y     (m_y),
    .out_a     (m_a),
    .out_side  (m_side)
  );

  // Second pass on (r, z): latitude and the full magnitude.
  rvep_cordic #(
    .STEPS (CORDIC_STEPS),
    .SW    ($bits(rvep_pkg::side2_t))
  ) u_cordic_lat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .in_x      (m_x),
    .in_y      (m_y),
    .in_a      (m_a),
    .in_side   (m_side),
    .out_valid (c2_valid),
    .out_ready (c2_ready),
    .out_x     (c2_x),
    .out_y     (c2_y),
    .out_a     (c2_a),
    .out_side  (c2_side)
  );

  rvep_back u_back (
    .clk            (clk),
    .rst            (rst),
    .earth_radius   (cfg.earth_radius),
    .in_valid       (c2_valid && (c2_y == c2_y)),
    .in_ready       (c2_ready),
    .in_x           (c2_x),
    .in_a           (c2_a),
    .in_side        (c2_side),
    .out_valid      (pole.valid),
    .out_ready      (pole.ready),
    .plate_id_out   (pole.plate_id_out),
    .rotation_rate  (pole.rotation_rate),
    .pole_latitude  (pole.pole_latitude),
    .pole_longitude (pole.pole_longitude),
    .zero_vector    (pole.zero_vector)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for rotation_vector_to_euler_pole: it drives rotation vectors
// through several register settings and checks each pole result against a model.
// Depends on rvep_pkg, rvep_in_if, rvep_out_if and the block's RTL.
module testbench;

  // The block's latency at the default CORDIC depth.
  localparam int PIPE_LATENCY = 6 + rvep_pkg::CORDIC_STEPS_DEF + 2 +
                                rvep_pkg::CORDIC_STEPS_DEF + 14;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX = 10;
  // A byte address past the last register; writes there must change nothing.
  localparam logic [rvep_pkg::ADDR_W-1:0] ADDR_UNUSED = 4'hC;

  localparam logic [63:0] SAT_MAG = 64'h7FFF_FFFF_FFFF;
  localparam logic [63:0] NORM_FLOOR = 64'h4000_0000_0000;
  localparam logic [63:0] GAIN_INV = 64'd2608131496;
  localparam logic [63:0] DEG_RATE = 64'd57295780;
  localparam longint HALF_TURN = 64'sd3019898880;
  localparam longint LAT_LIMIT = 64'sd5898240;
  localparam longint LON_LIMIT = 64'sd11796480;

  // atan(2^-i) in degrees, Q24.
  localparam longint ARCTAN_Q24 [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic [7:0]  plate;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
  } rot_vec_t;

  typedef struct {
    logic [7:0]  plate;
    logic [31:0] rate;
    logic [23:0] lat;
    logic [24:0] lon;
    logic        zero;
  } pole_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rvep_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rvep_in_if vec_if ();
  rvep_out_if pole_if ();

  rotation_vector_to_euler_pole u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .vec     (vec_if),
    .pole    (pole_if)
  );

  // The bench's own copy of the three registers.
  logic [63:0] gain_time;
  logic [63:0] gain_velocity;
  logic [63:0] radius;

  rot_vec_t vectors_to_send[$];
  pole_t poles_awaited[$];
  int mismatches;
  int cycle_count;
  logic vec_taken;
  logic pole_taken;
  int vec_gap;
  int pole_stall;
  logic no_gaps;
  logic no_stalls;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Multiply by a Q32 constant, flooring, the same way the block removes CORDIC gain.
  function automatic logic [63:0] mul_by_q32(input logic [63:0] a, input logic [63:0] k);
    return (a >> 32) * k + (((a & 64'hFFFF_FFFF) * k) >> 32);
  endfunction

  // CORDIC vectoring: drives py toward zero, returns the angle turned in Q24 degrees.
  function automatic longint rotate_to_axis(inout longint px, inout longint py);
    longint ang;
    longint dx;
    longint dy;
    ang = 0;
    for (int i = 0; i < rvep_pkg::CORDIC_STEPS_DEF && i < 32; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px += dx;
        py -= dy;
        ang += ARCTAN_Q24[i];
      end else begin
        px -= dx;
        py += dy;
        ang -= ARCTAN_Q24[i];
      end
    end
    return ang;
  endfunction

  function automatic longint round_angle(input longint a, input longint lim);
    longint t;
    t = (a + 128) >>> 8;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t;
  endfunction

  // Expected pole for one rotation vector under the current register values.
  function automatic pole_t predict_pole(input rot_vec_t v);
    logic [31:0] comp [3];
    logic [63:0] mag [3];
    logic        neg [3];
    logic [63:0] raw;
    logic [63:0] m1;
    logic [63:0] m2;
    logic [63:0] maxm;
    logic [63:0] hlen;
    logic [63:0] m;
    logic [63:0] rate;
    logic [63:0] erad;
    longint c [3];
    longint x;
    longint y;
    longint lon;
    longint lat;
    longint base;
    int s;
    pole_t p;
    comp[0] = v.rx;
    comp[1] = v.ry;
    comp[2] = v.rz;
    p.plate = v.plate;
    p.rate = '0;
    p.lat = '0;
    p.lon = '0;
    p.zero = 1'b0;
    maxm = 0;
    for (int k = 0; k < 3; k++) begin
      neg[k] = comp[k][31];
      raw = neg[k] ? (64'h1_0000_0000 - {32'd0, comp[k]}) : {32'd0, comp[k]};
      m1 = (raw * gain_time) >> 16;
      m2 = (((m1 >> 32) * gain_velocity) << 16) + (((m1 & 64'hFFFF_FFFF) * gain_velocity) >> 16);
      mag[k] = (m2 > SAT_MAG) ? SAT_MAG : m2;
      if (mag[k] > maxm) maxm = mag[k];
    end
    if (maxm == 0) begin
      p.zero = 1'b1;
      return p;
    end
    s = 0;
    while (maxm < NORM_FLOOR) begin
      maxm <<= 1;
      s++;
    end
    for (int k = 0; k < 3; k++) begin
      c[k] = longint'(mag[k] << s);
      if (neg[k]) c[k] = -c[k];
    end

    // Longitude pass on the horizontal components.
    x = c[0];
    y = c[1];
    lon = 0;
    if (x == 0 && y == 0) begin
      hlen = 0;
    end else begin
      base = 0;
      // A vector in the left half plane is turned half a revolution first.
      if (x < 0) begin
        base = (y >= 0) ? HALF_TURN : -HALF_TURN;
        x = -x;
        y = -y;
      end
      lon = round_angle(base + rotate_to_axis(x, y), LON_LIMIT);
      hlen = mul_by_q32((x > 0) ? 64'(x) : 64'd0, GAIN_INV);
    end

    // Latitude pass on the horizontal length and z.
    x = longint'(hlen);
    y = c[2];
    lat = round_angle(rotate_to_axis(x, y), LAT_LIMIT);
    m = mul_by_q32((x > 0) ? 64'(x) : 64'd0, GAIN_INV);
    if (s > 0) m = (m + (64'd1 << (s - 1))) >> s;

    erad = (radius != 0) ? radius : 64'd1;
    if (m >= (64'd1 << 37)) begin
      rate = 64'hFFFF_FFFF;
    end else begin
      rate = (m * DEG_RATE + erad / 2) / erad;
      if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
    end
    p.rate = rate[31:0];
    p.lat = lat[23:0];
    p.lon = lon[24:0];
    return p;
  endfunction

  // One APB write: a setup phase, then an access phase that ends at a rising edge.
  task automatic write_register(input logic [rvep_pkg::ADDR_W-1:0] addr,
                                input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    // pready is tied high, so the register was written at this edge.
    if (addr == {rvep_pkg::REG_TIME_SCALE, 2'b00}) gain_time = {32'd0, data};
    else if (addr == {rvep_pkg::REG_VELOCITY_RATIO, 2'b00}) gain_velocity = {32'd0, data};
    else if (addr == {rvep_pkg::REG_EARTH_RADIUS, 2'b00}) radius = {48'd0, data[15:0]};
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_gains(input logic [31:0] ts, input logic [31:0] vr, input logic [15:0] er);
    write_register({rvep_pkg::REG_TIME_SCALE, 2'b00}, ts);
    write_register({rvep_pkg::REG_VELOCITY_RATIO, 2'b00}, vr);
    write_register({rvep_pkg::REG_EARTH_RADIUS, 2'b00}, {16'd0, er});
  endtask

  // A random component: full range, small, a signed power of two, or zero.
  function automatic logic [31:0] random_component();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: v = $urandom_range(0, 32'h000F_FFFF);
      6: v = 32'd1 << $urandom_range(0, 31);
      7: v = $urandom_range(0, 255);
      default: v = 32'd0;
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic queue_vector(input logic [7:0] plate, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z);
    rot_vec_t v;
    v.plate = plate;
    v.rx = x;
    v.ry = y;
    v.rz = z;
    vectors_to_send.push_back(v);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      queue_vector(8'($urandom_range(1, 255)), random_component(), random_component(),
                   random_component());
    end
  endtask

  // Waits until every vector went in and every pole came back, then lets the
  // pipeline settle so that a register write cannot catch an item in flight.
  task automatic drain();
    while (vectors_to_send.size() != 0 || poles_awaited.size() != 0 || vec_if.valid) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  // Input driver: one transfer per item, with a random gap after each unless gaps are switched off.
  always @(negedge clk) begin
    rot_vec_t v;
    if (rst) begin
      vec_if.valid <= 1'b0;
    end else if (vec_if.valid && !vec_taken) begin
      // Hold the item until it is taken.
    end else if (vec_gap > 0) begin
      vec_gap <= vec_gap - 1;
      vec_if.valid <= 1'b0;
    end else if (vectors_to_send.size() != 0) begin
      v = vectors_to_send.pop_front();
      vec_if.plate_number <= v.plate;
      vec_if.rot_x <= v.rx;
      vec_if.rot_y <= v.ry;
      vec_if.rot_z <= v.rz;
      vec_if.valid <= 1'b1;
      if ($urandom_range(0, 40) == 0) no_gaps <= ~no_gaps;
      vec_gap <= no_gaps ? 0 : int'($urandom_range(0, 5));
    end else begin
      vec_if.valid <= 1'b0;
    end
  end

  // Output side: after each transfer, ready may stall at random, unless stalls are switched off.
  always @(negedge clk) begin
    int wait_cycles;
    if (rst) begin
      pole_if.ready <= 1'b0;
      pole_stall <= 0;
    end else if (pole_taken) begin
      if ($urandom_range(0, 40) == 0) no_stalls <= ~no_stalls;
      wait_cycles = int'($urandom_range(0, 5));
      if (no_stalls || wait_cycles == 0) begin
        pole_if.ready <= 1'b1;
      end else begin
        pole_stall <= wait_cycles - 1;
        pole_if.ready <= 1'b0;
      end
    end else if (pole_stall > 0) begin
      pole_stall <= pole_stall - 1;
      pole_if.ready <= 1'b0;
    end else begin
      pole_if.ready <= 1'b1;
    end
  end

  // Monitor: predicts on each input transfer, checks each output transfer.
  always @(posedge clk) begin
    pole_t want;
    vec_taken <= vec_if.valid && vec_if.ready && !rst;
    pole_taken <= pole_if.valid && pole_if.ready && !rst;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d poles still awaited",
               cycle_count, poles_awaited.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst) begin
      if (vec_if.valid && vec_if.ready) begin
        rot_vec_t v;
        v.plate = vec_if.plate_number;
        v.rx = vec_if.rot_x;
        v.ry = vec_if.rot_y;
        v.rz = vec_if.rot_z;
        poles_awaited.push_back(predict_pole(v));
      end
      if (pole_if.valid && pole_if.ready) begin
        if (poles_awaited.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < REPORT_MAX) begin
            $display("unexpected pole transfer for plate %0d", pole_if.plate_id_out);
          end
        end else begin
          want = poles_awaited.pop_front();
          if (pole_if.plate_id_out !== want.plate || pole_if.rotation_rate !== want.rate ||
              pole_if.pole_latitude !== want.lat || pole_if.pole_longitude !== want.lon ||
              pole_if.zero_vector !== want.zero) begin
            mismatches <= mismatches + 1;
            if (mismatches < REPORT_MAX) begin
              $display("pole mismatch: exp plate %0d rate %h lat %h lon %h zero %b",
                       want.plate, want.rate, want.lat, want.lon, want.zero);
              $display("               got plate %0d rate %h lat %h lon %h zero %b",
                       pole_if.plate_id_out, pole_if.rotation_rate, pole_if.pole_latitude,
                       pole_if.pole_longitude, pole_if.zero_vector);
            end
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    vec_if.valid = 1'b0;
    vec_if.plate_number = 8'd1;
    vec_if.rot_x = '0;
    vec_if.rot_y = '0;
    vec_if.rot_z = '0;
    pole_if.ready = 1'b0;
    gain_time = {32'd0, rvep_pkg::TIME_SCALE_RST};
    gain_velocity = {32'd0, rvep_pkg::VELOCITY_RATIO_RST};
    radius = {48'd0, rvep_pkg::EARTH_RADIUS_RST};
    mismatches = 0;
    cycle_count = 0;
    vec_taken = 1'b0;
    pole_taken = 1'b0;
    vec_gap = 0;
    pole_stall = 0;
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values first, with the directed vectors.
    queue_vector(8'd1, 32'd0, 32'd0, 32'd0);                     // zero vector
    queue_vector(8'd255, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_vector(8'd170, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vector(8'd85, 32'h0001_0000, 32'd0, 32'd0);           // on the x axis
    queue_vector(8'd2, 32'hFFFF_0000, 32'd0, 32'd0);            // negative x, y zero
    queue_vector(8'd3, 32'hFFFF_0000, 32'hFFFF_0000, 32'd0);    // third quadrant
    queue_vector(8'd4, 32'hFFFF_0000, 32'h0001_0000, 32'd5);    // second quadrant
    queue_vector(8'd5, 32'd0, 32'h0001_0000, 32'd0);
    queue_vector(8'd6, 32'd0, 32'hFFFF_0000, 32'd0);
    queue_vector(8'd7, 32'd0, 32'd0, 32'h0001_0000);            // north pole
    queue_vector(8'd8, 32'd0, 32'd0, 32'hFFFF_0000);            // south pole
    queue_vector(8'd9, 32'd1, 32'd0, 32'd0);                    // smallest nonzero
    queue_vector(8'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_vector(8'd11, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    queue_vector(8'd12, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    queue_vector(8'd13, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    queue_random(560);
    drain();

    // Largest gains and a radius of one: components and rate saturate.
    set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
    write_register(ADDR_UNUSED, $urandom);
    queue_vector(8'd20, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    queue_random(200);
    drain();

    // A zero time scale makes every vector the zero vector.
    set_gains(32'd0, 32'h0001_0000, 16'd6371);
    queue_random(50);
    drain();

    // A zero radius is handled as a radius of one.
    set_gains($urandom, $urandom, 16'd0);
    queue_random(200);
    drain();

    // Largest radius with small gains: tiny scaled components.
    set_gains(32'd1, 32'h0000_0100, 16'hFFFF);
    queue_random(250);
    drain();

    // A few random settings round out the run.
    for (int ph = 0; ph < 3; ph++) begin
      set_gains(32'($urandom_range(0, 32'h0010_0000)), $urandom,
                16'($urandom_range(1, 65535)));
      queue_random(200);
      drain();
    end

    if (mismatches == 0 && poles_awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rvep_pkg.sv
rtl/rvep_in_if.sv
rtl/rvep_out_if.sv
rtl/rvep_regs.sv
rtl/rvep_front.sv
rtl/rvep_cordic.sv
rtl/rvep_mid.sv
rtl/rvep_back.sv
rtl/rotation_vector_to_euler_pole.sv
verif/testbench.sv
